// ===== rtl/page_frame_bitmap_allocator_core_macros.svh =====
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_core_macros
// Assertion helpers used by the allocator core.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PFBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PFBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pfba_pkg.sv =====
// ----------------------------------------------------------------------------
// pfba_pkg
// Types and codes shared by the page frame bitmap allocator modules.
// ----------------------------------------------------------------------------
package pfba_pkg;

	localparam int CNT_W = 7;  // free-bit counts inside one word (up to 64)
	localparam int POS_W = 6;  // bit position inside one word

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_NOFIT = 2'd1,
		STAT_ZERO  = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_RMW,
		ST_DONE
	} state_t;

	// Summary of one bitmap word as seen by the first-fit search
	typedef struct packed {
		logic             valid;
		logic             all_free;
		logic             has_inner;
		logic [CNT_W-1:0] prefix;     // free bits counted up from bit 0
		logic [CNT_W-1:0] top;        // free bits counted down from the top bit
		logic [POS_W-1:0] inner_pos;  // lowest start of a fitting run inside the word
	} scan_res_t;

endpackage

// ===== rtl/pfba_map_ram.sv =====
// ----------------------------------------------------------------------------
// pfba_map_ram
// Used-bit map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfba_map_ram #(
	parameter int WORD_BITS = 64,
	parameter int DEPTH     = 512,
	parameter int AW        = 9
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic [AW-1:0]        raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/pfba_word_scan.sv =====
// ----------------------------------------------------------------------------
// pfba_word_scan
// Masks one bitmap word to the searchable frames and summarizes its free runs.
// ----------------------------------------------------------------------------
module pfba_word_scan #(
	parameter int WORD_BITS = 64,
	parameter int AW        = 9
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [WORD_BITS-1:0]         word_used,
	input  logic [AW-1:0]                word_idx,
	input  logic [AW-1:0]                last_w,
	input  logic [$clog2(WORD_BITS)-1:0] last_b,
	input  logic [8:0]                   len,
	output pfba_pkg::scan_res_t          res_s2,
	output logic [AW-1:0]                word_s2
);
	import pfba_pkg::*;

	localparam int BW = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] free_v;
	logic [WORD_BITS:0]   pow_v;
	logic [WORD_BITS:0]   acc_v;
	scan_res_t            res;

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			free_v[b] = !word_used[b]
				&& ((word_idx < last_w) || (word_idx == last_w && BW'(b) <= last_b))
				&& !(word_idx == '0 && b == 0);
		end

		// Run starts: build runs of len from power-of-two runs, constant shifts only.
		// The extra top bit stands for the empty run just past the word.
		pow_v = {1'b0, free_v};
		acc_v = '1;
		for (int j = 0; j <= BW; j++) begin
			if (len[j]) begin
				acc_v = pow_v & (acc_v >> (1 << j));
			end
			pow_v = pow_v & (pow_v >> (1 << j));
		end

		res           = '0;
		res.valid     = in_vld;
		res.all_free  = &free_v;
		res.prefix    = CNT_W'(WORD_BITS);
		res.top       = CNT_W'(WORD_BITS);
		res.has_inner = (len != '0) && (32'(len) <= 32'(WORD_BITS))
			&& (acc_v[WORD_BITS-1:0] != '0);
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!free_v[b]) begin
				res.prefix = CNT_W'(b);
			end
			if (acc_v[b]) begin
				res.inner_pos = POS_W'(b);
			end
		end
		for (int b = 0; b < WORD_BITS; b++) begin
			if (!free_v[b]) begin
				res.top = CNT_W'(WORD_BITS - 1 - b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else begin
			res_s2 <= res;
		end
	end

	always_ff @(posedge clk) begin
		word_s2 <= word_idx;
	end

endmodule

// ===== rtl/page_frame_bitmap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_core
// First-fit page frame allocator over a used-bit map held in one memory.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): kind, first_frame, run_length. Output
// channel (out_valid/out_stall): status, granted_frame, frames_in_use, one
// result item per input item. cfg_we/cfg_wdata write frames_present at once.
// One item is worked at a time. A free does one read-modify-write per map
// word that the run touches. An allocate reads one map word per cycle from
// word 0, searching up to and including the fit (or up to the frame limit),
// then does one read-modify-write per word of the run. Items rejected by the
// length, range or full checks go straight to the result.
// After reset the block sweeps the map to all used, one word a cycle, and
// holds in_stall high until the sweep is done.
// A finished result waits in the output register while out_stall is high;
// the next item is still taken and worked, and its result waits for the slot.
// ----------------------------------------------------------------------------
`include "page_frame_bitmap_allocator_core_macros.svh"

module page_frame_bitmap_allocator_core #(
	parameter int NUM_FRAMES = 32768,
	parameter int WORD_BITS  = 64,
	parameter int MAX_RUN    = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [14:0] first_frame,
	input  logic [8:0]  run_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [14:0] granted_frame,
	output logic [15:0] frames_in_use
);
	import pfba_pkg::*;

	localparam int BW        = $clog2(WORD_BITS);
	localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int XW        = (AW + BW > 17) ? AW + BW : 17;
	localparam int CW        = 10;
	localparam int CMAX      = (1 << CW) - 1;
	localparam int RST_TOTAL = (NUM_FRAMES < 32768) ? NUM_FRAMES : 32768;

	state_t state_q, state_d;

	logic [15:0]    fp_q;
	logic [15:0]    total_q;
	logic           kind_q;
	logic [8:0]     len_q;
	logic [XW-1:0]  lo_q, hi_q;
	logic [AW-1:0]  rd_addr_q, end_w_q, clr_addr_q;
	logic           rd_done_q;
	logic [CW-1:0]  carry_q;
	status_t        stat_q;
	logic [14:0]    grant_q;
	logic           rv_s1;
	logic [AW-1:0]  rw_s1;

	logic           out_valid_q;
	logic [1:0]     out_status_q;
	logic [14:0]    out_grant_q;
	logic [15:0]    out_use_q;

	logic [15:0]    limit;
	logic [XW-1:0]  lim_m1;
	logic [AW-1:0]  last_w;
	logic [BW-1:0]  last_b;

	logic                 issue;
	logic [WORD_BITS-1:0] rdata;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;

	scan_res_t      sres_s2;
	logic [AW-1:0]  sword_s2;

	logic           accept;
	status_t        chk_stat;
	logic [XW-1:0]  free_lo, free_hi;
	logic           prefix_hit, found;
	logic [XW-1:0]  gr, gr_hi;
	logic [CW:0]    carry_sum;
	logic [CW-1:0]  carry_next;
	logic [16:0]    total_add;

	logic [WORD_BITS-1:0] wmask;
	logic [CNT_W-1:0]     clr_cnt;
	logic                 rmw_wr, rmw_last;

	assign limit  = ({16'b0, fp_q} > 32'(NUM_FRAMES)) ? 16'(NUM_FRAMES) : fp_q;
	assign lim_m1 = XW'(limit) - XW'(1);
	assign last_w = lim_m1[BW +: AW];
	assign last_b = lim_m1[BW-1:0];

	assign in_stall      = (state_q != ST_IDLE);
	assign accept        = in_valid && (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign granted_frame = out_grant_q;
	assign frames_in_use = out_use_q;

	assign issue = ((state_q == ST_SCAN) || (state_q == ST_RMW)) && !rd_done_q;

	// ---- early checks on the incoming item
	assign free_lo = XW'(first_frame);
	assign free_hi = free_lo + XW'(run_length) - XW'(1);

	always_comb begin
		if (run_length == '0) begin
			chk_stat = STAT_ZERO;
		end else if (32'(run_length) > 32'(MAX_RUN)) begin
			chk_stat = STAT_RANGE;
		end else if (kind == KIND_ALLOC) begin
			chk_stat = (total_q >= limit) ? STAT_NOFIT : STAT_OK;
		end else begin
			chk_stat = (17'(first_frame) + 17'(run_length) > 17'(limit)) ? STAT_RANGE : STAT_OK;
		end
	end

	// ---- first-fit combine: word summary plus run carried in from below
	assign prefix_hit = (11'(carry_q) + 11'(sres_s2.prefix)) >= 11'(len_q);
	assign found      = (state_q == ST_SCAN) && sres_s2.valid
		&& (prefix_hit || sres_s2.has_inner);
	assign gr         = prefix_hit ? (XW'({sword_s2, BW'(0)}) - XW'(carry_q))
		: XW'({sword_s2, sres_s2.inner_pos[BW-1:0]});
	assign gr_hi      = gr + XW'(len_q) - XW'(1);
	assign carry_sum  = (CW + 1)'(carry_q) + (CW + 1)'(WORD_BITS);
	assign carry_next = sres_s2.all_free
		? ((carry_sum > (CW + 1)'(CMAX)) ? CW'(CMAX) : carry_sum[CW-1:0])
		: CW'(sres_s2.top);
	assign total_add  = 17'(total_q) + 17'(len_q);

	// ---- read-modify-write of one word of the run
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			wmask[b] = (rw_s1 != lo_q[BW +: AW] || BW'(b) >= lo_q[BW-1:0])
				&& (rw_s1 != hi_q[BW +: AW] || BW'(b) <= hi_q[BW-1:0])
				&& !(kind_q == KIND_FREE && rw_s1 == '0 && b == 0);
		end
	end

	assign clr_cnt  = CNT_W'($countones(rdata & wmask));
	assign rmw_wr   = (state_q == ST_RMW) && rv_s1;
	assign rmw_last = rmw_wr && (rw_s1 == end_w_q);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '1;
		end else begin
			mem_we    = rmw_wr;
			mem_waddr = rw_s1;
			mem_wdata = (kind_q == KIND_ALLOC) ? (rdata | wmask) : (rdata & ~wmask);
		end
	end

	pfba_map_ram #(
		.WORD_BITS (WORD_BITS),
		.DEPTH     (MAP_WORDS),
		.AW        (AW)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	pfba_word_scan #(
		.WORD_BITS (WORD_BITS),
		.AW        (AW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (rv_s1 && (state_q == ST_SCAN) && !found),
		.word_used (rdata),
		.word_idx  (rw_s1),
		.last_w    (end_w_q),
		.last_b    (last_b),
		.len       (len_q),
		.res_s2    (sres_s2),
		.word_s2   (sword_s2)
	);

	// ---- sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == AW'(MAP_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (chk_stat != STAT_OK) begin
						state_d = ST_DONE;
					end else if (kind == KIND_ALLOC) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_RMW;
					end
				end
			end
			ST_SCAN: begin
				if (found) begin
					state_d = ST_RMW;
				end else if (sres_s2.valid && sword_s2 == end_w_q) begin
					state_d = ST_DONE;
				end
			end
			ST_RMW: begin
				if (rmw_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q        <= 16'd32768;
			total_q     <= 16'(RST_TOTAL);
			clr_addr_q  <= '0;
			rd_done_q   <= 1'b1;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				fp_q <= cfg_wdata;
			end
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			// drop reads still in flight once the fit is found
			rv_s1 <= issue && !found;
			if (issue) begin
				rd_done_q <= (rd_addr_q == end_w_q);
			end
			if (accept && chk_stat == STAT_OK) begin
				rd_done_q <= 1'b0;
			end
			if (found) begin
				rd_done_q <= 1'b0;
				total_q   <= (total_add > 17'hFFFF) ? 16'hFFFF : total_add[15:0];
			end
			if (rmw_wr && kind_q == KIND_FREE) begin
				total_q <= (total_q > 16'(clr_cnt)) ? (total_q - 16'(clr_cnt)) : '0;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_addr_q <= rd_addr_q + AW'(1);
		end
		rw_s1 <= rd_addr_q;
		if (state_q == ST_SCAN && sres_s2.valid) begin
			carry_q <= carry_next;
		end
		if (accept) begin
			kind_q  <= kind;
			len_q   <= run_length;
			stat_q  <= chk_stat;
			grant_q <= '0;
			carry_q <= '0;
			if (kind == KIND_ALLOC) begin
				rd_addr_q <= '0;
				end_w_q   <= last_w;
			end else begin
				lo_q      <= free_lo;
				hi_q      <= free_hi;
				rd_addr_q <= free_lo[BW +: AW];
				end_w_q   <= free_hi[BW +: AW];
			end
		end
		if (state_q == ST_SCAN && !found && sres_s2.valid && sword_s2 == end_w_q) begin
			stat_q <= STAT_NOFIT;
		end
		if (found) begin
			lo_q      <= gr;
			hi_q      <= gr_hi;
			rd_addr_q <= gr[BW +: AW];
			end_w_q   <= gr_hi[BW +: AW];
			grant_q   <= gr[14:0];
			stat_q    <= STAT_OK;
		end
		if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			out_status_q <= stat_q;
			out_grant_q  <= grant_q;
			out_use_q    <= total_q;
		end
	end

	`PFBA_ASSERT_NOW(a_no_write_in_scan, state_q == ST_SCAN, !mem_we,
		"map written during search")
	`PFBA_ASSERT_NOW(a_read_only_when_busy, rv_s1,
		state_q == ST_SCAN || state_q == ST_RMW, "map read outside search or update")
	`PFBA_ASSERT_NEXT(a_grant_not_zero, found, lo_q != '0 && state_q == ST_RMW,
		"frame zero granted")

endmodule

// ===== dv/pfba_checker.sv =====
// ----------------------------------------------------------------------------
// pfba_checker
// Watches both channels and the register port of the page frame allocator,
// keeps its own copy of the used-frame map, predicts one result per accepted
// item and compares every result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module pfba_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        kind,
	input  logic [14:0] first_frame,
	input  logic [8:0]  run_length,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [14:0] granted_frame,
	input  logic [15:0] frames_in_use,
	output int          pending,
	output int          fail_count,
	output int          results_seen,
	output int          grants_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import pfba_pkg::*;

	localparam int FRAMES  = 32768;
	localparam int RUN_MAX = 256;

	typedef struct packed {
		status_t     status;
		logic [14:0] granted;
		logic [15:0] in_use;
	} alloc_result_t;

	bit            frame_used [FRAMES];
	int            used_count;
	logic [15:0]   frames_present_q;
	alloc_result_t result_q[$];

	function automatic int frame_limit();
		return (frames_present_q > FRAMES) ? FRAMES : int'(frames_present_q);
	endfunction

	function automatic alloc_result_t predict_item(kind_t op, int first, int len);
		alloc_result_t r;
		int limit;
		int run;
		int f;
		bit found;
		limit = frame_limit();
		r.status = STAT_OK;
		r.granted = '0;
		run = 0;
		found = 0;
		if (len == 0) begin
			r.status = STAT_ZERO;
		end else if (len > RUN_MAX) begin
			r.status = STAT_RANGE;
		end else if (op == KIND_ALLOC) begin
			if (used_count < limit) begin
				for (f = 1; f < limit && !found; f++) begin
					if (frame_used[f]) begin
						run = 0;
					end else begin
						run++;
						if (run == len) begin
							r.granted = 15'(f + 1 - len);
							found = 1;
						end
					end
				end
			end
			if (found) begin
				for (f = r.granted; f < r.granted + len; f++)
					frame_used[f] = 1'b1;
				used_count += len;
				if (used_count > 65535)
					used_count = 65535;
			end else begin
				r.status = STAT_NOFIT;
			end
		end else if (first + len > limit) begin
			r.status = STAT_RANGE;
		end else begin
			// frame zero stays used; count only bits that really flip
			for (f = first; f < first + len; f++) begin
				if (f != 0 && frame_used[f]) begin
					frame_used[f] = 1'b0;
					if (used_count > 0)
						used_count--;
				end
			end
		end
		r.in_use = 16'(used_count);
		return r;
	endfunction

	assign pending = result_q.size();

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		bit bad;
		if (!arst_n) begin
			foreach (frame_used[i])
				frame_used[i] = 1'b1;
			frames_present_q = 16'd32768;
			used_count = FRAMES;
			result_q.delete();
			fail_count <= 0;
			results_seen <= 0;
			grants_seen <= 0;
		end else begin
			if (cfg_we)
				frames_present_q = cfg_wdata;
			if (in_valid && !in_stall)
				result_q.push_back(predict_item(kind_t'(kind), first_frame, run_length));
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (result_q.size() == 0) begin
					$error("result with no item outstanding: status %0d frame %0d used %0d",
						status, granted_frame, frames_in_use);
					fail_count <= fail_count + 1;
				end else begin
					want = result_q.pop_front();
					bad = 1'b0;
					if (want.status == STAT_OK && granted_frame != 0)
						grants_seen <= grants_seen + 1;
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						bad = 1'b1;
					end
					if (granted_frame !== want.granted) begin
						$error("granted_frame: expected %0d, got %0d",
							want.granted, granted_frame);
						bad = 1'b1;
					end
					if (frames_in_use !== want.in_use) begin
						$error("frames_in_use: expected %0d, got %0d",
							want.in_use, frames_in_use);
						bad = 1'b1;
					end
					if (bad)
						fail_count <= fail_count + 1;
				end
			end
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the page frame allocator: a directed pass over the length,
// range, full-map and frame-zero cases, then random free/allocate traffic
// under several frame counts, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import pfba_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = 1'b0;
	logic [14:0] first_frame = '0;
	logic [8:0]  run_length = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [14:0] granted_frame;
	logic [15:0] frames_in_use;

	int pending, fail_count, results_seen, grants_seen;
	int items_sent = 0;
	int cycle_count = 0;
	int stall_mode = 0;
	int gap_mode = 0;
	int frame_window = 32768;

	always #5 clk = ~clk;

	page_frame_bitmap_allocator_core i_dut (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .kind,
		.first_frame, .run_length, .out_valid, .out_stall, .status,
		.granted_frame, .frames_in_use
	);

	pfba_checker i_checker (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .kind,
		.first_frame, .run_length, .out_valid, .out_stall, .status,
		.granted_frame, .frames_in_use, .pending, .fail_count, .results_seen,
		.grants_seen
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// mode 0: never stall, 1: light, 2: heavy with long holds
	always @(negedge clk) begin
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 2);
			default: out_stall <= ($urandom_range(0, 99) < 85);
		endcase
	end

	always begin
		repeat ($urandom_range(50, 400)) @(negedge clk);
		stall_mode = $urandom_range(0, 2);
		gap_mode = $urandom_range(0, 2);
	end

	task automatic idle_gap();
		int n;
		n = 0;
		if (gap_mode != 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: n = 0;
				5, 6, 7, 8: n = $urandom_range(1, 3);
				default: n = $urandom_range(10, 60);
			endcase
		end
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(kind_t op, int first, int len);
		idle_gap();
		kind <= op;
		first_frame <= 15'(first);
		run_length <= 9'(len);
		in_valid <= 1'b1;
		#1;
		while (in_stall) @(negedge clk) #1;
		@(negedge clk);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_frames_present(int value);
		drain();
		cfg_wdata <= 16'(value);
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		frame_window = (value > 32768 || value == 0) ? 32768 : value;
	endtask

	task automatic random_item();
		int len, first, w;
		case ($urandom_range(0, 19))
			0: len = 0;
			1: len = $urandom_range(257, 511);
			2, 3, 4: len = $urandom_range(17, 256);
			default: len = $urandom_range(1, 16);
		endcase
		// keep most traffic low in the map so allocate scans stay short
		w = (frame_window > 2048 && $urandom_range(0, 3) != 0) ? 2048 : frame_window;
		if ($urandom_range(0, 9) == 0)
			first = $urandom_range(0, 32767);
		else
			first = $urandom_range(0, w - 1);
		if ($urandom_range(0, 1))
			send_item(KIND_FREE, first, len);
		else
			send_item(KIND_ALLOC, $urandom_range(0, 32767), len);
	endtask

	initial begin
		int settings[7] = '{32768, 4096, 1, 0, 300, 65535, 1000};
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: map starts full
		send_item(KIND_ALLOC, 0, 1);
		send_item(KIND_ALLOC, 0, 0);
		send_item(KIND_FREE, 5, 0);
		send_item(KIND_FREE, 0, 257);
		send_item(KIND_ALLOC, 32767, 511);
		send_item(KIND_FREE, 32767, 2);
		send_item(KIND_FREE, 32767, 1);
		send_item(KIND_FREE, 32512, 256);
		send_item(KIND_FREE, 0, 4);
		send_item(KIND_FREE, 0, 4);
		send_item(KIND_ALLOC, 0, 3);
		send_item(KIND_ALLOC, 0, 1);
		send_item(KIND_ALLOC, 0, 256);
		send_item(KIND_ALLOC, 0, 255);
		send_item(KIND_FREE, 32600, 100);
		send_item(KIND_ALLOC, 0, 2);
		send_item(KIND_FREE, 10, 256);
		send_item(KIND_ALLOC, 0, 256);
		send_item(KIND_ALLOC, 0, 256);
		// hold off until everything has come back
		drain();
		send_item(KIND_ALLOC, 0, 1);

		foreach (settings[i]) begin
			if (i != 0)
				write_frames_present(settings[i]);
			repeat (170) random_item();
		end
		write_frames_present(32768);
		repeat (30) random_item();
		drain();
		repeat (600) @(negedge clk);

		$display("Sent %0d items over %0d frame-count settings; %0d results checked, %0d grants.",
			items_sent, $size(settings) + 1, results_seen, grants_seen);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pfba_pkg.sv
rtl/pfba_map_ram.sv
rtl/pfba_word_scan.sv
rtl/page_frame_bitmap_allocator_core.sv
dv/pfba_checker.sv
dv/tb_top.sv
